// File: src/scmi_plr_pkg.sv
// ----------------------------------------------------------------------------
// scmi_plr_pkg
// shared codes, constants and helpers of the scmi perf level responder
// ----------------------------------------------------------------------------
package scmi_plr_pkg;

  // protocol numbers
  localparam logic [7:0] PROTO_BASE = 8'd16;
  localparam logic [7:0] PROTO_PERF = 8'd19;

  // base protocol messages
  localparam logic [7:0] BASE_MSG_VERSION    = 8'd0;
  localparam logic [7:0] BASE_MSG_ATTRIBUTES = 8'd1;
  localparam logic [7:0] BASE_MSG_VENDOR     = 8'd3;
  localparam logic [7:0] BASE_MSG_SUBVENDOR  = 8'd4;
  localparam logic [7:0] BASE_MSG_PROTO_LIST = 8'd6;
  localparam logic [7:0] BASE_MSG_AGENT      = 8'd7;

  // perf protocol messages
  localparam logic [7:0] PERF_MSG_VERSION      = 8'd0;
  localparam logic [7:0] PERF_MSG_ATTRIBUTES   = 8'd1;
  localparam logic [7:0] PERF_MSG_DOMAIN_ATTRS = 8'd3;
  localparam logic [7:0] PERF_MSG_DESC_LEVELS  = 8'd4;
  localparam logic [7:0] PERF_MSG_LEVEL_SET    = 8'd7;
  localparam logic [7:0] PERF_MSG_LEVEL_GET    = 8'd8;

  // fixed payload words
  localparam logic [31:0] PROTO_VERSION   = 32'h0001_0000;
  localparam logic [31:0] BASE_ATTRS      = 32'h0000_0101;
  localparam logic [31:0] SUSTAINED_KHZ   = 32'd1000000;
  localparam logic [31:0] DOM_ATTR_FLAGS  = 32'hC000_0000;
  localparam logic [31:0] VENDOR_W0       = 32'h546E_6558;
  localparam logic [31:0] VENDOR_W1       = 32'h706F_6F72;
  localparam logic [31:0] VENDOR_W2       = 32'h0000_0073;
  localparam logic [31:0] SUBVENDOR_W0    = 32'h656E_6552;
  localparam logic [31:0] SUBVENDOR_W1    = 32'h0073_6173;
  localparam logic [31:0] AGENT_W0        = 32'h004E_4558;
  localparam logic [31:0] DOM_NAME_PREFIX = 32'h7570_6376;  // "vcpu"
  localparam logic [31:0] LEVEL_LATENCY   = 32'd1;

  // levels described per reply page
  localparam int unsigned LEVELS_PER_REPLY = 5;

  typedef enum logic [1:0] {
    ST_SUCCESS        = 2'd0,
    ST_NOT_SUPPORTED  = 2'd1,
    ST_INVALID_PARAMS = 2'd2,
    ST_OUT_OF_RANGE   = 2'd3
  } status_e;

  function automatic logic [31:0] status_word(status_e st);
    logic [31:0] w;
    case (st)
      ST_SUCCESS:        w = 32'h0000_0000;
      ST_NOT_SUPPORTED:  w = 32'hFFFF_FFFF;
      ST_INVALID_PARAMS: w = 32'hFFFF_FFFE;
      ST_OUT_OF_RANGE:   w = 32'hFFFF_FFFB;
      default:           w = 32'h0000_0000;
    endcase
    return w;
  endfunction

endpackage

// File: src/scmi_plr_if.sv
// ----------------------------------------------------------------------------
// scmi_plr_if
// request and response channels of the scmi perf level responder
// ----------------------------------------------------------------------------
interface scmi_plr_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  protocol_id;
  logic [7:0]  message_id;
  logic [31:0] first_arg;
  logic [31:0] second_arg;

  modport source (output valid, output protocol_id, output message_id,
                  output first_arg, output second_arg, input ready);
  modport sink   (input valid, input protocol_id, input message_id,
                  input first_arg, input second_arg, output ready);
endinterface

interface scmi_plr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [4:0]  word_index;
  logic        last;
  logic [1:0]  status;
  logic [6:0]  byte_length;
  logic        level_changed;
  logic [2:0]  changed_domain;
  logic [3:0]  new_level;

  modport source (output valid, output word, output word_index, output last,
                  output status, output byte_length, output level_changed,
                  output changed_domain, output new_level, input ready);
  modport sink   (input valid, input word, input word_index, input last,
                  input status, input byte_length, input level_changed,
                  input changed_domain, input new_level, output ready);
endinterface

// File: src/scmi_perf_level_responder.sv
// status: a request's status word is shown once the sequencer has passed decode (S_EVAL) into S_EMIT
// response: n = 1..17 words, one per cycle while rsp.ready is high, after the level memory read
//   registered at request transfer and the decode; no new request is taken until the last word
// reset: all domain levels read as zero (per-entry valid bits), domain count is 1,
//   the block is ready for a request in the first cycle after reset
// ----------------------------------------------------------------------------
// scmi_perf_level_responder
// scmi base and perf protocol agent keeping one performance level per domain
// ----------------------------------------------------------------------------
module scmi_perf_level_responder
  import scmi_plr_pkg::*;
#(
  parameter int unsigned MAX_DOMAINS = 8,
  parameter int unsigned LEVEL_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  scmi_plr_req_if.sink   req,
  scmi_plr_rsp_if.source rsp
);

  // level memory address and stored level widths
  localparam int unsigned AW  = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
  localparam int unsigned LVW = $clog2(LEVEL_COUNT);
  // width of a 1-based level (1..LEVEL_COUNT)
  localparam int unsigned LCW = $clog2(LEVEL_COUNT + 1);
  localparam int unsigned ND_CAP = (MAX_DOMAINS < 15) ? MAX_DOMAINS : 15;

  // one-hot sequencer
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  // shape of the payload beyond the first data word
  typedef enum logic [2:0] {
    K_PLAIN,
    K_VENDOR,
    K_SUBVENDOR,
    K_PROTO_LIST,
    K_DOM_ATTR,
    K_LEVELS
  } kind_e;

  state_e state_q, state_d;

  // configuration
  logic [3:0] dom_cnt_q;

  // latched request
  logic [7:0]  proto_q, msg_q;
  logic [31:0] a_q, b_q;

  // level memory, valid bits and registered read port
  logic [LVW-1:0]         lvl_mem [MAX_DOMAINS];
  logic [MAX_DOMAINS-1:0] lvl_vld_q;
  logic [LVW-1:0]         rd_q;
  logic                   rd_vld_q;

  // response context
  status_e     st_q, st_d;
  kind_e       kind_q, kind_d;
  logic [31:0] w1_q, w1_d;
  logic [6:0]  len_q, len_d;
  logic [4:0]  nwords_q;
  logic        chg_q, chg_d;
  logic [2:0]  chg_dom_q;
  logic [3:0]  chg_lvl_q;
  logic [15:0] name_q, name_d;
  logic [LCW-1:0] pv_q;
  logic [1:0]  phase_q;
  logic [4:0]  idx_q;

  logic        req_xfer, rsp_xfer, mem_we;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [3:0]  nd;
  logic        dom_ok;
  logic [LVW-1:0] level_rd;
  logic [31:0] b_m1;
  logic [31:0] left, ret32, rem32;
  logic [3:0]  ret;
  logic [3:0]  a_lo;
  logic [2*LCW-1:0] pv_sq;
  logic [31:0] word;

  assign req.ready = state_q[0];
  assign req_xfer  = req.valid && req.ready;
  assign rsp_xfer  = rsp.valid && rsp.ready;

  assign rd_addr = req.first_arg[AW-1:0];
  assign wr_addr = a_q[AW-1:0];

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_cnt_q <= 4'd1;
    end else if (cfg_we_i) begin
      dom_cnt_q <= cfg_wdata_i;
    end
  end

  // effective domain count, capped by the memory depth
  assign nd = (int'(dom_cnt_q) < MAX_DOMAINS) ? dom_cnt_q : 4'(ND_CAP);

  // ---------------------------------------------------------------------------
  // level memory: read on request transfer, written back during decode
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lvl_mem[wr_addr] <= b_m1[LVW-1:0];
    end
    if (req_xfer) begin
      rd_q <= lvl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) begin
        lvl_vld_q[wr_addr] <= 1'b1;
      end
      if (req_xfer) begin
        rd_vld_q <= lvl_vld_q[rd_addr];
      end
    end
  end

  // an entry never written reads as level zero
  assign level_rd = rd_vld_q ? rd_q : '0;

  // ---------------------------------------------------------------------------
  // request latch
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      proto_q <= req.protocol_id;
      msg_q   <= req.message_id;
      a_q     <= req.first_arg;
      b_q     <= req.second_arg;
    end
  end

  // ---------------------------------------------------------------------------
  // decode: status, first data word, length and level update
  // ---------------------------------------------------------------------------
  assign dom_ok = a_q < {28'd0, nd};
  assign b_m1   = b_q - 32'd1;
  assign a_lo   = a_q[3:0];

  // level page: levels left from the index and levels in this page
  assign left  = 32'(LEVEL_COUNT) - b_q;
  assign ret32 = (left < 32'(LEVELS_PER_REPLY)) ? left : 32'(LEVELS_PER_REPLY);
  assign rem32 = (left > 32'(LEVELS_PER_REPLY)) ? left - 32'(LEVELS_PER_REPLY) : 32'd0;
  assign ret   = ret32[3:0];

  // domain name digits after the "vcpu" prefix, little-endian bytes
  always_comb begin
    if (a_lo < 4'd10) begin
      name_d = {8'h00, 8'h30 + {4'd0, a_lo}};
    end else begin
      name_d = {8'h30 + {4'd0, a_lo - 4'd10}, 8'h31};
    end
  end

  always_comb begin
    st_d   = ST_SUCCESS;
    kind_d = K_PLAIN;
    w1_d   = '0;
    len_d  = 7'd8;
    chg_d  = 1'b0;
    mem_we = 1'b0;
    case (proto_q)
      PROTO_BASE: begin
        case (msg_q)
          BASE_MSG_VERSION: begin
            w1_d  = PROTO_VERSION;
            len_d = 7'd12;
          end
          BASE_MSG_ATTRIBUTES: begin
            w1_d  = BASE_ATTRS;
            len_d = 7'd12;
          end
          BASE_MSG_VENDOR: begin
            w1_d   = VENDOR_W0;
            kind_d = K_VENDOR;
            len_d  = 7'd18;
          end
          BASE_MSG_SUBVENDOR: begin
            w1_d   = SUBVENDOR_W0;
            kind_d = K_SUBVENDOR;
            len_d  = 7'd16;
          end
          BASE_MSG_PROTO_LIST: begin
            if (a_q == 32'd0) begin
              w1_d   = 32'd1;
              kind_d = K_PROTO_LIST;
              len_d  = 7'd16;
            end else begin
              st_d = ST_OUT_OF_RANGE;
            end
          end
          BASE_MSG_AGENT: begin
            w1_d  = AGENT_W0;
            len_d = 7'd12;
          end
          default: st_d = ST_NOT_SUPPORTED;
        endcase
      end
      PROTO_PERF: begin
        case (msg_q)
          PERF_MSG_VERSION: begin
            w1_d  = PROTO_VERSION;
            len_d = 7'd12;
          end
          PERF_MSG_ATTRIBUTES: begin
            w1_d  = {28'd0, nd};
            len_d = 7'd24;
          end
          PERF_MSG_DOMAIN_ATTRS: begin
            if (dom_ok) begin
              w1_d   = DOM_ATTR_FLAGS;
              kind_d = K_DOM_ATTR;
              len_d  = 7'd40;
            end else begin
              st_d = ST_OUT_OF_RANGE;
            end
          end
          PERF_MSG_DESC_LEVELS: begin
            // a negative index reads as a large value and fails here
            if (!dom_ok || b_q >= 32'(LEVEL_COUNT)) begin
              st_d = ST_OUT_OF_RANGE;
            end else begin
              w1_d   = {rem32[15:0], ret32[15:0]};
              kind_d = K_LEVELS;
              len_d  = 7'd12 + 7'd12 * {3'd0, ret};
            end
          end
          PERF_MSG_LEVEL_SET: begin
            if (!dom_ok) begin
              st_d = ST_OUT_OF_RANGE;
            end else if (b_q == 32'd0 || b_q > 32'(LEVEL_COUNT)) begin
              st_d = ST_INVALID_PARAMS;
            end else if (level_rd != b_m1[LVW-1:0]) begin
              // write back only on a real change, which raises the event
              mem_we = state_q[1];
              chg_d  = 1'b1;
            end
          end
          PERF_MSG_LEVEL_GET: begin
            if (dom_ok) begin
              w1_d  = 32'(level_rd) + 32'd1;
              len_d = 7'd12;
            end else begin
              st_d = ST_OUT_OF_RANGE;
            end
          end
          default: st_d = ST_NOT_SUPPORTED;
        endcase
      end
      default: st_d = ST_NOT_SUPPORTED;
    endcase
    // any failure leaves the status word only
    if (st_d != ST_SUCCESS) begin
      len_d  = 7'd8;
      kind_d = K_PLAIN;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req_xfer) state_d = S_EVAL;
      S_EVAL:  state_d = S_EMIT;
      S_EMIT:  if (rsp_xfer && rsp.last) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EVAL) begin
        idx_q   <= '0;
        phase_q <= '0;
      end else if (rsp_xfer) begin
        idx_q <= idx_q + 5'd1;
        // level triplets start at the third word
        if (idx_q >= 5'd2) begin
          phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
        end
      end
    end
  end

  // response context, captured at the end of decode
  always_ff @(posedge clk_i) begin
    if (state_q == S_EVAL) begin
      st_q      <= st_d;
      kind_q    <= kind_d;
      w1_q      <= w1_d;
      len_q     <= len_d;
      nwords_q  <= 5'((len_d - 7'd1) >> 2);
      chg_q     <= chg_d;
      chg_dom_q <= chg_d ? a_q[2:0] : 3'd0;
      chg_lvl_q <= chg_d ? b_m1[3:0] : 4'd0;
      name_q    <= name_d;
      pv_q      <= b_q[LCW-1:0] + LCW'(1);
    end else if (rsp_xfer && idx_q >= 5'd2 && phase_q == 2'd2) begin
      pv_q <= pv_q + LCW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // response word select
  // ---------------------------------------------------------------------------
  assign pv_sq = pv_q * pv_q;

  always_comb begin
    word = '0;
    if (idx_q == 5'd0) begin
      word = status_word(st_q);
    end else if (idx_q == 5'd1) begin
      word = w1_q;
    end else begin
      case (kind_q)
        K_VENDOR: begin
          if (idx_q == 5'd2) word = VENDOR_W1;
          if (idx_q == 5'd3) word = VENDOR_W2;
        end
        K_SUBVENDOR: begin
          if (idx_q == 5'd2) word = SUBVENDOR_W1;
        end
        K_PROTO_LIST: begin
          if (idx_q == 5'd2) word = {24'd0, PROTO_PERF};
        end
        K_DOM_ATTR: begin
          case (idx_q)
            5'd3:    word = SUSTAINED_KHZ;
            5'd4:    word = 32'(LEVEL_COUNT / 2);
            5'd5:    word = DOM_NAME_PREFIX;
            5'd6:    word = {16'd0, name_q};
            default: word = '0;
          endcase
        end
        K_LEVELS: begin
          // value, power, latency per level
          case (phase_q)
            2'd0:    word = 32'(pv_q);
            2'd1:    word = 32'(pv_sq);
            2'd2:    word = LEVEL_LATENCY;
            default: word = '0;
          endcase
        end
        default: word = '0;
      endcase
    end
  end

  assign rsp.valid          = state_q[2];
  assign rsp.word           = word;
  assign rsp.word_index     = idx_q;
  assign rsp.last           = (idx_q == nwords_q - 5'd1);
  assign rsp.status         = st_q;
  assign rsp.byte_length    = len_q;
  assign rsp.level_changed  = chg_q;
  assign rsp.changed_domain = chg_dom_q;
  assign rsp.new_level      = chg_lvl_q;

`ifndef ASSERT_OFF
  // no new request while a response is being sent
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready)
    else $error("request taken during response");

  // the final word returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.ready && rsp.last |=> state_q == S_IDLE)
    else $error("sequencer not idle after final word");

  // a change event only on a successful response
  a_chg_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.level_changed |-> rsp.status == ST_SUCCESS)
    else $error("change event with failing status");

  // the first word is the status word of the reported status
  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.word_index == 5'd0 |-> rsp.word == status_word(st_q))
    else $error("status word mismatch");

  // a failing response is the status word alone
  a_fail_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status != ST_SUCCESS |-> rsp.last && rsp.byte_length == 7'd8)
    else $error("failing response longer than status word");
`endif

endmodule
